FILE: rtl/babd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// babd_pkg - shared types and constants of the binary arithmetic bit decoder
// Request and result layouts, opcode names and probability clamp limits.
// ----------------------------------------------------------------------------
package babd_pkg;

    // opcode of a request
    localparam logic OP_BYTE   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // probability clamp limits
    localparam logic [15:0] PROB_MIN = 16'd1;
    localparam logic [15:0] PROB_MAX = 16'd65534;

    // renormalisation limits
    localparam logic [2:0]  BYTES_FULL = 3'd4;
    localparam logic [31:0] WORD_ONES  = 32'hffff_ffff;

    // classified request as it travels from front end to back end
    typedef struct packed {
        logic        op;
        logic [15:0] prob;
        logic [7:0]  cbyte;
    } t_item;

    // one result
    typedef struct packed {
        logic       bit_out;
        logic [2:0] needed;
        logic       err;
    } t_result;

    // queue occupancy flags seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

FILE: rtl/binary_arithmetic_bit_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_arithmetic_bit_decoder - carryless 32-bit binary arithmetic decoder
// Usage:
//   Input channel (i_in_valid / o_in_stall): a request with i_opcode = 1
//   decodes one bit with i_probability (chance of a one, clamped to
//   1..65534); i_opcode = 0 feeds i_compressed_byte into the code word.
//   Output channel (o_out_valid / i_out_stall): one result per request with
//   the decoded bit, the compressed bytes still owed and an order flag.
//   After each decode, feed exactly o_bytes_needed byte requests before the
//   next decode; a request out of that order is flagged and ignored.
//   After acceptance a request passes the intake register, the queue
//   storage and the engine result register. Throughput is one request
//   a cycle while nothing stalls, set by the combinational split/compare/
//   renormalise path of the engine, which carries the range between requests.
//   Reset (synchronous, active low) empties the pipeline, sets the range to
//   the full word and owes four bytes. When the receiver stalls, the result
//   holds, the queue (QUEUE_DEPTH requests) fills and then the input stalls.
// ----------------------------------------------------------------------------
module binary_arithmetic_bit_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [15:0] i_probability,
    input  logic [7:0]  i_compressed_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_decoded_bit,
    output logic [2:0]  o_bytes_needed,
    output logic        o_order_error
);

    babd_pkg::t_queue_status w_q_status;
    babd_pkg::t_item         w_push_item;
    babd_pkg::t_item         w_head;
    babd_pkg::t_result       w_result;
    logic                    w_push;
    logic                    w_pop;

    // request intake
    babd_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_opcode          (i_opcode),
        .i_probability     (i_probability),
        .i_compressed_byte (i_compressed_byte),
        .i_q_status        (w_q_status),
        .o_push            (w_push),
        .o_item            (w_push_item)
    );

    // decoupling queue
    babd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_push_item),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    // decode engine
    babd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_q_status  (w_q_status),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (w_result)
    );

    assign o_decoded_bit  = w_result.bit_out;
    assign o_bytes_needed = w_result.needed;
    assign o_order_error  = w_result.err;

endmodule

FILE: rtl/babd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// babd_front - request intake
// Takes requests, clamps the probability and holds one classified request
// until the queue has room for it.
// ----------------------------------------------------------------------------
module babd_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_opcode,
    input  logic [15:0]             i_probability,
    input  logic [7:0]              i_compressed_byte,
    input  babd_pkg::t_queue_status i_q_status,
    output logic                    o_push,
    output babd_pkg::t_item         o_item
);

    logic            r_valid;
    logic            n_valid;
    babd_pkg::t_item r_item;
    babd_pkg::t_item n_item;
    logic            w_accept;
    logic [15:0]     w_prob;

    // stall only while the held request cannot move on
    assign o_in_stall = r_valid && i_q_status.full;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_q_status.full;
    assign o_item     = r_item;

    // clamp probability into the usable band
    always_comb begin
        if (i_probability < babd_pkg::PROB_MIN) begin
            w_prob = babd_pkg::PROB_MIN;
        end else if (i_probability > babd_pkg::PROB_MAX) begin
            w_prob = babd_pkg::PROB_MAX;
        end else begin
            w_prob = i_probability;
        end
    end

    // holding register
    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        if (w_accept) begin
            n_valid     = 1'b1;
            n_item.op    = i_opcode;
            n_item.prob  = w_prob;
            n_item.cbyte = i_compressed_byte;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

endmodule

FILE: rtl/babd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// babd_queue - request queue
// Small FIFO between front end and back end so that each can stall alone.
// ----------------------------------------------------------------------------
module babd_queue #(
    parameter int DEPTH = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  babd_pkg::t_item         i_item,
    input  logic                    i_pop,
    output babd_pkg::t_item         o_head,
    output babd_pkg::t_queue_status o_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CFULL = CW'(DEPTH);

    babd_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0]   r_wptr;
    logic [PW-1:0]   n_wptr;
    logic [PW-1:0]   r_rptr;
    logic [PW-1:0]   n_rptr;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic            w_push;
    logic            w_pop;

    assign o_status.full  = (r_count == CFULL);
    assign o_status.empty = (r_count == '0);
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_head = r_mem[r_rptr];

    // pointer and count update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_push) begin
            n_wptr = (r_wptr == LAST) ? '0 : r_wptr + 1'b1;
        end
        if (w_pop) begin
            n_rptr = (r_rptr == LAST) ? '0 : r_rptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

FILE: rtl/babd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// babd_back - decode engine
// Executes one queued request a cycle while not stalled: splits the range,
// decides the bit, renormalises, shifts code bytes in, and registers the result.
// ----------------------------------------------------------------------------
module babd_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  babd_pkg::t_item         i_head,
    input  babd_pkg::t_queue_status i_q_status,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output babd_pkg::t_result       o_result
);

    logic [31:0]       r_low;
    logic [31:0]       n_low;
    logic [31:0]       r_high;
    logic [31:0]       n_high;
    logic [31:0]       r_code;
    logic [31:0]       n_code;
    logic [2:0]        r_pending;
    logic [2:0]        n_pending;
    logic              r_out_valid;
    logic              n_out_valid;
    babd_pkg::t_result r_out;
    babd_pkg::t_result n_out;

    logic              w_exec;
    logic              w_err;
    logic [31:0]       w_span;
    logic [31:0]       w_upper;
    logic [31:0]       w_lower;
    logic [31:0]       w_mid;
    logic              w_bit;
    logic [31:0]       w_nlow;
    logic [31:0]       w_nhigh;
    logic [31:0]       w_agree;
    logic [2:0]        w_shift;
    logic [31:0]       w_rlow;
    logic [31:0]       w_rhigh;

    // take the head whenever the result register is free
    assign w_exec      = !i_q_status.empty && (!r_out_valid || !i_out_stall);
    assign o_pop       = w_exec;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    // out-of-order check
    assign w_err = (i_head.op == babd_pkg::OP_DECODE) ? (r_pending != 3'd0)
                                                      : (r_pending == 3'd0);

    // split point: low + span*p/65536 in two 16x16 halves
    assign w_span  = r_high - r_low;
    assign w_upper = {16'd0, w_span[31:16]} * {16'd0, i_head.prob};
    assign w_lower = {16'd0, w_span[15:0]} * {16'd0, i_head.prob};
    assign w_mid   = r_low + w_upper + {16'd0, w_lower[31:16]};
    assign w_bit   = (r_code <= w_mid);
    assign w_nlow  = w_bit ? r_low : w_mid + 32'd1;
    assign w_nhigh = w_bit ? w_mid : r_high;
    assign w_agree = w_nlow ^ w_nhigh;

    // count leading bytes on which the bounds agree
    always_comb begin
        if (w_agree[31:24] != 8'd0) begin
            w_shift = 3'd0;
        end else if (w_agree[23:16] != 8'd0) begin
            w_shift = 3'd1;
        end else if (w_agree[15:8] != 8'd0) begin
            w_shift = 3'd2;
        end else if (w_agree[7:0] != 8'd0) begin
            w_shift = 3'd3;
        end else begin
            w_shift = babd_pkg::BYTES_FULL;
        end
    end

    // shift the agreed bytes out
    always_comb begin
        unique case (w_shift)
            3'd0: begin
                w_rlow  = w_nlow;
                w_rhigh = w_nhigh;
            end
            3'd1: begin
                w_rlow  = {w_nlow[23:0], 8'h00};
                w_rhigh = {w_nhigh[23:0], 8'hff};
            end
            3'd2: begin
                w_rlow  = {w_nlow[15:0], 16'h0000};
                w_rhigh = {w_nhigh[15:0], 16'hffff};
            end
            3'd3: begin
                w_rlow  = {w_nlow[7:0], 24'h000000};
                w_rhigh = {w_nhigh[7:0], 24'hffffff};
            end
            default: begin
                w_rlow  = 32'd0;
                w_rhigh = babd_pkg::WORD_ONES;
            end
        endcase
    end

    // state and result update
    always_comb begin
        n_low       = r_low;
        n_high      = r_high;
        n_code      = r_code;
        n_pending   = r_pending;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (w_exec) begin
            n_out_valid = 1'b1;
            if (!w_err) begin
                if (i_head.op == babd_pkg::OP_DECODE) begin
                    n_low     = w_rlow;
                    n_high    = w_rhigh;
                    n_pending = w_shift;
                end else begin
                    n_code    = {r_code[23:0], i_head.cbyte};
                    n_pending = r_pending - 3'd1;
                end
            end
            n_out.bit_out = (i_head.op == babd_pkg::OP_DECODE) && !w_err && w_bit;
            n_out.needed  = n_pending;
            n_out.err     = w_err;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low       <= 32'd0;
            r_high      <= babd_pkg::WORD_ONES;
            r_code      <= 32'd0;
            r_pending   <= babd_pkg::BYTES_FULL;
            r_out_valid <= 1'b0;
        end else begin
            r_low       <= n_low;
            r_high      <= n_high;
            r_code      <= n_code;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // owed byte count never exceeds a full code word
    a_pending_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= babd_pkg::BYTES_FULL)
        else $error("pending byte count out of range");

    // an ignored request leaves the coder state untouched
    a_err_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec && w_err) |=> ($stable(r_low) && $stable(r_high) &&
                               $stable(r_code) && $stable(r_pending)))
        else $error("ignored request changed coder state");

    // a flagged result never carries a decoded one
    a_err_bit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.err) |-> !r_out.bit_out)
        else $error("flagged result carries a decoded bit");

    // result reports the count left in the state
    a_needed_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exec |=> (r_out.needed == r_pending))
        else $error("reported byte count differs from state");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the binary arithmetic bit decoder
// A short table of hand-picked requests goes in first. It covers order errors,
// both probability clamps and a decode that collapses the interval to a
// point. Long runs of well-formed decode/byte sequences with random content
// follow, mixed with out-of-order noise. Every result is compared with its
// table entry or an in-bench model of the range coder. Both sides idle at
// random except in the closing stretch.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RANDOM_REQUESTS = 1930;
    localparam int QUIET_REQUESTS  = 300;
    localparam int TAIL_CYCLES     = 20;
    localparam int CYCLE_LIMIT     = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_opcode;
    logic [15:0] i_probability;
    logic [7:0]  i_compressed_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_decoded_bit;
    logic [2:0]  o_bytes_needed;
    logic        o_order_error;

    binary_arithmetic_bit_decoder dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_opcode          (i_opcode),
        .i_probability     (i_probability),
        .i_compressed_byte (i_compressed_byte),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_decoded_bit     (o_decoded_bit),
        .o_bytes_needed    (o_bytes_needed),
        .o_order_error     (o_order_error)
    );

    // one row of the directed table
    typedef struct packed {
        logic              op;
        logic [15:0]       prob;
        logic [7:0]        cbyte;
        logic              fixed;
        babd_pkg::t_result res;
    } t_row;

    t_row              directed_rows[$];
    babd_pkg::t_result expected_results[$];

    // bench copy of the coder state
    logic [31:0] coder_low;
    logic [31:0] coder_high;
    logic [31:0] coder_code;
    logic [2:0]  coder_owed;

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  out_stall_left = 0;
    bit  quiet          = 1'b0;

    // clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // cycle limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** binary_arithmetic_bit_decoder: FAILED **");
            $finish;
        end
    end

    // one line per mismatch
    task automatic report_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s expected %0d got %0d",
                 cycle_count, what, want, got);
    endtask

    // range coder model: advances the bench state, returns the result
    function automatic babd_pkg::t_result decode_request(input logic op,
                                                         input logic [15:0] prob,
                                                         input logic [7:0] cbyte);
        babd_pkg::t_result res;
        logic [15:0]       p;
        logic [31:0]       span;
        logic [63:0]       upper;
        logic [63:0]       lower;
        logic [31:0]       mid;
        logic [2:0]        shifts;
        res = '0;
        if (op == babd_pkg::OP_DECODE) begin
            if (coder_owed != 3'd0) begin
                res.err = 1'b1;
            end else begin
                p = prob;
                if (p < babd_pkg::PROB_MIN) p = babd_pkg::PROB_MIN;
                if (p > babd_pkg::PROB_MAX) p = babd_pkg::PROB_MAX;
                span  = coder_high - coder_low;
                upper = 64'(span[31:16]) * 64'(p);
                lower = (64'(span[15:0]) * 64'(p)) >> 16;
                mid   = coder_low + upper[31:0] + lower[31:0];
                if (coder_code <= mid) begin
                    res.bit_out = 1'b1;
                    coder_high  = mid;
                end else begin
                    coder_low = mid + 32'd1;
                end
                // shift out leading bytes that agree
                shifts = 3'd0;
                while (shifts < babd_pkg::BYTES_FULL &&
                       (coder_low[31:24] == coder_high[31:24])) begin
                    coder_low  = {coder_low[23:0], 8'h00};
                    coder_high = {coder_high[23:0], 8'hff};
                    shifts++;
                end
                coder_owed = shifts;
            end
        end else begin
            if (coder_owed == 3'd0) begin
                res.err = 1'b1;
            end else begin
                coder_code = {coder_code[23:0], cbyte};
                coder_owed--;
            end
        end
        res.needed = coder_owed;
        return res;
    endfunction

    task automatic add_row(input logic op, input logic [15:0] prob, input logic [7:0] cbyte,
                           input logic fixed, input logic e_bit, input logic [2:0] e_need,
                           input logic e_err);
        t_row row;
        row.op          = op;
        row.prob        = prob;
        row.cbyte       = cbyte;
        row.fixed       = fixed;
        row.res.bit_out = e_bit;
        row.res.needed  = e_need;
        row.res.err     = e_err;
        directed_rows.push_back(row);
    endtask

    // present one request, hold it until accepted, queue its expected result
    task automatic send_request(input logic op, input logic [15:0] prob, input logic [7:0] cbyte,
                                input logic fixed, input babd_pkg::t_result fixed_res);
        babd_pkg::t_result pred;
        int                gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 15);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_opcode          <= op;
        i_probability     <= prob;
        i_compressed_byte <= cbyte;
        do @(posedge i_clk); while (o_in_stall);
        pred = decode_request(op, prob, cbyte);
        expected_results.push_back(fixed ? fixed_res : pred);
    endtask

    function automatic logic [15:0] pick_probability();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
            1:       return 16'($urandom_range(0, 255));
            2:       return 16'($urandom_range(65280, 65535));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // receiver stalls in bursts
    always @(posedge i_clk) begin
        if (out_stall_left > 0) out_stall_left--;
        else if (!quiet && $urandom_range(0, 9) == 0) out_stall_left = $urandom_range(1, 15);
        i_out_stall <= (out_stall_left != 0);
    end

    // result checker
    always @(posedge i_clk) begin
        babd_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, bytes_needed", -1, int'(o_bytes_needed));
            end else begin
                want = expected_results.pop_front();
                if (o_decoded_bit !== want.bit_out)
                    report_mismatch("decoded_bit", int'(want.bit_out), int'(o_decoded_bit));
                if (o_bytes_needed !== want.needed)
                    report_mismatch("bytes_needed", int'(want.needed), int'(o_bytes_needed));
                if (o_order_error !== want.err)
                    report_mismatch("order_error", int'(want.err), int'(o_order_error));
            end
        end
    end

    // stimulus
    initial begin
        babd_pkg::t_result no_res;
        t_row              row;
        logic              op;
        no_res = '0;

        i_rst_n           <= 1'b0;
        i_in_valid        <= 1'b0;
        i_opcode          <= babd_pkg::OP_BYTE;
        i_probability     <= 16'h0000;
        i_compressed_byte <= 8'h00;

        coder_low  = 32'h0;
        coder_high = babd_pkg::WORD_ONES;
        coder_code = 32'h0;
        coder_owed = babd_pkg::BYTES_FULL;

        // decode with bytes owed, code fill, byte with none owed
        add_row(babd_pkg::OP_DECODE, 16'h8000, 8'h3c, 1'b1, 1'b0, 3'd4, 1'b1);
        add_row(babd_pkg::OP_BYTE,   16'hffff, 8'h00, 1'b1, 1'b0, 3'd3, 1'b0);
        add_row(babd_pkg::OP_BYTE,   16'h0000, 8'hff, 1'b1, 1'b0, 3'd2, 1'b0);
        add_row(babd_pkg::OP_BYTE,   16'h1234, 8'hff, 1'b1, 1'b0, 3'd1, 1'b0);
        add_row(babd_pkg::OP_BYTE,   16'hedcb, 8'hff, 1'b1, 1'b0, 3'd0, 1'b0);
        add_row(babd_pkg::OP_BYTE,   16'h5a5a, 8'ha5, 1'b1, 1'b0, 3'd0, 1'b1);
        // steer the interval down to a single point, then collapse it
        add_row(babd_pkg::OP_DECODE, 16'h0101, 8'h00, 1'b0, 1'b0, 3'd0, 1'b0);
        add_row(babd_pkg::OP_DECODE, 16'hff00, 8'h00, 1'b0, 1'b0, 3'd0, 1'b0);
        add_row(babd_pkg::OP_DECODE, 16'h00fe, 8'h00, 1'b0, 1'b0, 3'd0, 1'b0);
        add_row(babd_pkg::OP_DECODE, 16'h0001, 8'h00, 1'b0, 1'b0, 3'd0, 1'b0);
        add_row(babd_pkg::OP_DECODE, 16'hffff, 8'hff, 1'b0, 1'b0, 3'd0, 1'b0);
        // interval back to full, four bytes owed again
        add_row(babd_pkg::OP_DECODE, 16'h0000, 8'h81, 1'b1, 1'b0, 3'd4, 1'b1);
        add_row(babd_pkg::OP_BYTE,   16'h0000, 8'h00, 1'b1, 1'b0, 3'd3, 1'b0);
        add_row(babd_pkg::OP_BYTE,   16'h0000, 8'h00, 1'b1, 1'b0, 3'd2, 1'b0);
        add_row(babd_pkg::OP_BYTE,   16'h0000, 8'h00, 1'b1, 1'b0, 3'd1, 1'b0);
        add_row(babd_pkg::OP_BYTE,   16'h0000, 8'h00, 1'b1, 1'b0, 3'd0, 1'b0);
        // low clamp, then refill and the high clamp
        add_row(babd_pkg::OP_DECODE, 16'h0000, 8'h00, 1'b0, 1'b0, 3'd0, 1'b0);
        add_row(babd_pkg::OP_BYTE,   16'h0000, 8'hff, 1'b0, 1'b0, 3'd0, 1'b0);
        add_row(babd_pkg::OP_BYTE,   16'hffff, 8'h7f, 1'b0, 1'b0, 3'd0, 1'b0);
        add_row(babd_pkg::OP_DECODE, 16'hffff, 8'h00, 1'b0, 1'b0, 3'd0, 1'b0);
        add_row(babd_pkg::OP_DECODE, 16'h8000, 8'h00, 1'b0, 1'b0, 3'd0, 1'b0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            send_request(row.op, row.prob, row.cbyte, row.fixed, row.res);
        end

        // mostly well-formed streams, some out-of-order noise
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == RANDOM_REQUESTS - QUIET_REQUESTS) quiet = 1'b1;
            op = (coder_owed != 3'd0) ? babd_pkg::OP_BYTE : babd_pkg::OP_DECODE;
            if ($urandom_range(0, 9) == 0) op = ~op;
            send_request(op, pick_probability(), 8'($urandom_range(0, 255)), 1'b0, no_res);
        end
        i_in_valid <= 1'b0;

        // drain, then a short tail for stray results
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch("results missing", 0, expected_results.size());

        if (mismatch_count == 0) begin
            $display("** binary_arithmetic_bit_decoder: PASSED **");
        end else begin
            $display("** binary_arithmetic_bit_decoder: FAILED **");
        end
        $finish;
    end

endmodule
